/* design/tbl_pkg.sv */
`timescale 1ns / 1ps

package tbl_pkg;

  // Input coordinate width and fraction bits of the weights.
  localparam int CoordW = 16;
  localparam int FracBits = 16;

  // Output weight width and configuration register width.
  localparam int WeightW = 20;
  localparam int TolW = 16;

  // Area and numerator sums, and their magnitudes.
  localparam int SumW = 2 * CoordW + 2;
  localparam int MagW = SumW - 1;

  // Quotient bits kept beyond the fraction; a larger quotient is always clamped.
  localparam int GuardBits = 2;
  localparam int QuotW = FracBits + GuardBits;
  localparam int DivStages = QuotW;

  // Width used for the clamp compares.
  localparam int CmpW = WeightW + 1;

  localparam logic [TolW-1:0] TolReset = TolW'(66);
  localparam logic signed [CmpW-1:0] WeightOne = CmpW'(1) <<< FracBits;

  // Per-item flags that travel beside the dividers.
  typedef struct packed {
    logic valid;
    logic degen;
    logic neg1;
    logic big1;
    logic neg2;
    logic big2;
  } side_t;

endpackage

/* design/tbl_qdiv.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider: quot = floor(num * 2^FracBits / den), one
// quotient bit per stage. The caller guarantees num < den * 2^GuardBits.
module tbl_qdiv import tbl_pkg::*; (
  input  logic             clk_i,
  input  logic [MagW-1:0]  num_i,
  input  logic [MagW-1:0]  den_i,
  output logic [QuotW-1:0] quot_o
);

  logic [MagW-1:0]      rem_q  [DivStages];
  logic [MagW-1:0]      den_q  [DivStages];
  logic [GuardBits-1:0] low_q  [DivStages];
  logic [QuotW-1:0]     quot_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_step
    logic [MagW-1:0]      rem_in;
    logic [MagW-1:0]      den_in;
    logic [GuardBits-1:0] low_in;
    logic [QuotW-1:0]     quot_in;
    logic [MagW:0]        trial;
    logic                 fit;

    // The first stage starts from the dividend with its guard bits held back.
    if (s == 0) begin : g_first
      assign rem_in  = {{GuardBits{1'b0}}, num_i[MagW-1:GuardBits]};
      assign den_in  = den_i;
      assign low_in  = num_i[GuardBits-1:0];
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign low_in  = low_q[s-1];
      assign quot_in = quot_q[s-1];
    end

    // Bring down the next dividend bit and try one subtraction.
    assign trial = {rem_in, low_in[GuardBits-1]};
    assign fit   = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= fit ? MagW'(trial - {1'b0, den_in}) : trial[MagW-1:0];
      den_q[s]  <= den_in;
      low_q[s]  <= {low_in[GuardBits-2:0], 1'b0};
      quot_q[s] <= {quot_in[QuotW-2:0], fit};
    end
  end

  assign quot_o = quot_q[DivStages-1];

endmodule

/* design/triangle_barycentric_locate.sv */
`timescale 1ns / 1ps

// Barycentric point-in-triangle locator.
// A transaction is accepted at a rising edge with start high and busy low;
// busy is always low, so a new triangle and query point may enter every
// cycle. Each accepted transaction yields exactly one result, shown on the
// result ports for one cycle with done_o high.
// Throughput is one result per cycle: the two quotients come from 18-stage
// pipelined dividers that retire one quotient bit per stage, set by the
// 16 fraction bits plus two guard bits.
// The tolerance register is written over its own valid/ready channel, which
// is always ready; write it only while no transaction is in flight.
// Reset clears the pipeline valid bits and loads tolerance with 66 (about
// 0.001 in Q16). The receiver cannot stall, so results are never held back.
// A zero doubled area gives zero weights with degenerate set and inside low.
module triangle_barycentric_locate import tbl_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [CoordW-1:0]  vertex1_x_i,
  input  logic signed [CoordW-1:0]  vertex1_y_i,
  input  logic signed [CoordW-1:0]  vertex2_x_i,
  input  logic signed [CoordW-1:0]  vertex2_y_i,
  input  logic signed [CoordW-1:0]  vertex3_x_i,
  input  logic signed [CoordW-1:0]  vertex3_y_i,
  input  logic signed [CoordW-1:0]  point_x_i,
  input  logic signed [CoordW-1:0]  point_y_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [TolW-1:0]           cfg_tolerance_i,
  output logic                      done_o,
  output logic signed [WeightW-1:0] weight_one_o,
  output logic signed [WeightW-1:0] weight_two_o,
  output logic signed [WeightW-1:0] weight_three_o,
  output logic                      inside_res_o,
  output logic                      degenerate_o
);

  localparam int ProdW = 2 * CoordW;
  localparam int MixW = 2 * CoordW + 1;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Tolerance register.
  logic [TolW-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_tolerance_i;
    end
  end

  // Stage 1: coordinate differences and all products.
  logic signed [CoordW:0] dy23, dx32, dy31, dx13;
  assign dy23 = {vertex2_y_i[CoordW-1], vertex2_y_i} - {vertex3_y_i[CoordW-1], vertex3_y_i};
  assign dx32 = {vertex3_x_i[CoordW-1], vertex3_x_i} - {vertex2_x_i[CoordW-1], vertex2_x_i};
  assign dy31 = {vertex3_y_i[CoordW-1], vertex3_y_i} - {vertex1_y_i[CoordW-1], vertex1_y_i};
  assign dx13 = {vertex1_x_i[CoordW-1], vertex1_x_i} - {vertex3_x_i[CoordW-1], vertex3_x_i};

  logic                    s1_valid_q;
  logic signed [ProdW-1:0] p23_q, p32_q, p31_q, p13_q, p12_q, p21_q;
  logic signed [MixW-1:0]  m1x_q, m1y_q, m2x_q, m2y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    p23_q <= vertex2_x_i * vertex3_y_i;
    p32_q <= vertex3_x_i * vertex2_y_i;
    p31_q <= vertex3_x_i * vertex1_y_i;
    p13_q <= vertex1_x_i * vertex3_y_i;
    p12_q <= vertex1_x_i * vertex2_y_i;
    p21_q <= vertex2_x_i * vertex1_y_i;
    m1x_q <= dy23 * point_x_i;
    m1y_q <= dx32 * point_y_i;
    m2x_q <= dy31 * point_x_i;
    m2y_q <= dx13 * point_y_i;
  end

  // Stage 2: doubled area and the two numerators.
  logic                   s2_valid_q;
  logic signed [SumW-1:0] area_q, num1_q, num2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    area_q <= SumW'(p23_q) + SumW'(p12_q) + SumW'(p31_q)
            - SumW'(p21_q) - SumW'(p32_q) - SumW'(p13_q);
    num1_q <= SumW'(p23_q) - SumW'(p32_q) + SumW'(m1x_q) + SumW'(m1y_q);
    num2_q <= SumW'(p31_q) - SumW'(p13_q) + SumW'(m2x_q) + SumW'(m2y_q);
  end

  // Stage 3: signs, magnitudes and the too-large-quotient checks.
  logic [SumW-1:0] area_abs, num1_abs, num2_abs;
  logic [MagW-1:0] den_mag;
  logic            degen;

  assign degen    = area_q == '0;
  assign area_abs = area_q[SumW-1] ? SumW'(-area_q) : SumW'(area_q);
  assign num1_abs = num1_q[SumW-1] ? SumW'(-num1_q) : SumW'(num1_q);
  assign num2_abs = num2_q[SumW-1] ? SumW'(-num2_q) : SumW'(num2_q);
  assign den_mag  = degen ? MagW'(1) : area_abs[MagW-1:0];

  side_t           s3_side_q;
  logic [MagW-1:0] s3_num1_q, s3_num2_q, s3_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_side_q <= '0;
    end else begin
      s3_side_q.valid <= s2_valid_q;
      s3_side_q.degen <= degen;
      s3_side_q.neg1  <= num1_q[SumW-1] ^ area_q[SumW-1];
      s3_side_q.neg2  <= num2_q[SumW-1] ^ area_q[SumW-1];
      s3_side_q.big1  <= {2'b00, num1_abs[MagW-1:0]} >= {den_mag, {GuardBits{1'b0}}};
      s3_side_q.big2  <= {2'b00, num2_abs[MagW-1:0]} >= {den_mag, {GuardBits{1'b0}}};
    end
  end

  // The numerator of a big quotient is replaced by zero; its flag forces the clamp later.
  always_ff @(posedge clk_i) begin
    s3_den_q  <= den_mag;
    s3_num1_q <= ({2'b00, num1_abs[MagW-1:0]} >= {den_mag, {GuardBits{1'b0}}})
                 ? '0 : num1_abs[MagW-1:0];
    s3_num2_q <= ({2'b00, num2_abs[MagW-1:0]} >= {den_mag, {GuardBits{1'b0}}})
                 ? '0 : num2_abs[MagW-1:0];
  end

  // Divider stages, with the flags carried alongside.
  logic [QuotW-1:0] quot1, quot2;

  tbl_qdiv u_div1 (
    .clk_i  (clk_i),
    .num_i  (s3_num1_q),
    .den_i  (s3_den_q),
    .quot_o (quot1)
  );

  tbl_qdiv u_div2 (
    .clk_i  (clk_i),
    .num_i  (s3_num2_q),
    .den_i  (s3_den_q),
    .quot_o (quot2)
  );

  side_t side_q [DivStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivStages; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side_q[0] <= s3_side_q;
      for (int i = 1; i < DivStages; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Output stage: sign, clamp against the tolerance band, third weight.
  side_t                 side_end;
  logic signed [CmpW-1:0] q1, q2, w1, w2, w3, tol_lo, tol_hi;
  logic                   clip1, clip2;

  assign side_end = side_q[DivStages-1];
  assign tol_lo   = -CmpW'(signed'({1'b0, tol_q}));
  assign tol_hi   = WeightOne + CmpW'(signed'({1'b0, tol_q}));
  assign q1 = side_end.neg1 ? -CmpW'(signed'({1'b0, quot1}))
                            : CmpW'(signed'({1'b0, quot1}));
  assign q2 = side_end.neg2 ? -CmpW'(signed'({1'b0, quot2}))
                            : CmpW'(signed'({1'b0, quot2}));

  always_comb begin
    clip1 = 1'b1;
    clip2 = 1'b1;
    if (side_end.big1) begin
      w1 = side_end.neg1 ? '0 : WeightOne;
    end else if (q1 < tol_lo) begin
      w1 = '0;
    end else if (q1 > tol_hi) begin
      w1 = WeightOne;
    end else begin
      w1 = q1;
      clip1 = 1'b0;
    end
    if (side_end.big2) begin
      w2 = side_end.neg2 ? '0 : WeightOne;
    end else if (q2 < tol_lo) begin
      w2 = '0;
    end else if (q2 > tol_hi) begin
      w2 = WeightOne;
    end else begin
      w2 = q2;
      clip2 = 1'b0;
    end
    w3 = WeightOne - w1 - w2;
  end

  logic done_q, inside_q, degen_q;
  logic signed [WeightW-1:0] w1_q, w2_q, w3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_end.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    degen_q  <= side_end.degen;
    inside_q <= !side_end.degen && !clip1 && !clip2;
    w1_q     <= side_end.degen ? '0 : w1[WeightW-1:0];
    w2_q     <= side_end.degen ? '0 : w2[WeightW-1:0];
    w3_q     <= side_end.degen ? '0 : w3[WeightW-1:0];
  end

  assign done_o         = done_q;
  assign weight_one_o   = w1_q;
  assign weight_two_o   = w2_q;
  assign weight_three_o = w3_q;
  assign inside_res_o   = inside_q;
  assign degenerate_o   = degen_q;

endmodule

/* bench/triangle_barycentric_locate_checker.sv */
`timescale 1ns / 1ps

module triangle_barycentric_locate_checker import tbl_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [CoordW-1:0]  vertex1_x_i,
  input  logic signed [CoordW-1:0]  vertex1_y_i,
  input  logic signed [CoordW-1:0]  vertex2_x_i,
  input  logic signed [CoordW-1:0]  vertex2_y_i,
  input  logic signed [CoordW-1:0]  vertex3_x_i,
  input  logic signed [CoordW-1:0]  vertex3_y_i,
  input  logic signed [CoordW-1:0]  point_x_i,
  input  logic signed [CoordW-1:0]  point_y_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_o,
  input  logic [TolW-1:0]           cfg_tolerance_i,
  input  logic                      done_o,
  input  logic signed [WeightW-1:0] weight_one_o,
  input  logic signed [WeightW-1:0] weight_two_o,
  input  logic signed [WeightW-1:0] weight_three_o,
  input  logic                      inside_res_o,
  input  logic                      degenerate_o,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic signed [WeightW-1:0] w1;
    logic signed [WeightW-1:0] w2;
    logic signed [WeightW-1:0] w3;
    logic                      in_tri;
    logic                      degen;
  } locate_t;

  locate_t     expected_q[$];
  logic [15:0] tol_shadow;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  // Truncating fixed-point quotient with the integer part capped at 2^20.
  function automatic longint fixed_quotient(longint num, longint den);
    logic        neg;
    longint unsigned a, b, ip, rem, frac, mag;
    neg = (num < 0) != (den < 0);
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    ip = a / b;
    rem = a % b;
    frac = 0;
    if (ip > 64'd1048576) begin
      ip = 64'd1048576;
      rem = 0;
    end
    for (int i = 0; i < FracBits; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= b) begin
        rem = rem - b;
        frac = frac | 1;
      end
    end
    mag = (ip << FracBits) | frac;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_weight(longint q, longint tol, inout logic in_tri);
    longint one;
    one = longint'(1) << FracBits;
    if (q < -tol) begin
      in_tri = 1'b0;
      return 0;
    end
    if (q > one + tol) begin
      in_tri = 1'b0;
      return one;
    end
    return q;
  endfunction

  function automatic locate_t locate_point(longint x1, longint y1, longint x2, longint y2,
                                           longint x3, longint y3, longint px, longint py,
                                           longint tol);
    locate_t r;
    longint  d, n1, n2, w1, w2, one;
    logic    in_tri;
    one = longint'(1) << FracBits;
    in_tri = 1'b1;
    r = '0;
    d = x2*y3 + x1*y2 + y1*x3 - x2*y1 - x3*y2 - x1*y3;
    if (d == 0) begin
      r.degen = 1'b1;
      return r;
    end
    n1 = (x2*y3 - x3*y2) + (y2 - y3)*px + (x3 - x2)*py;
    n2 = (x3*y1 - x1*y3) + (y3 - y1)*px + (x1 - x3)*py;
    w1 = clamp_weight(fixed_quotient(n1, d), tol, in_tri);
    w2 = clamp_weight(fixed_quotient(n2, d), tol, in_tri);
    r.w1 = w1[WeightW-1:0];
    r.w2 = w2[WeightW-1:0];
    r.w3 = WeightW'(one - w1 - w2);
    r.in_tri = in_tri;
    return r;
  endfunction

  // Track configuration, predict accepted transactions, compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    locate_t got, exp_r;
    if (!rst_ni) begin
      tol_shadow <= TolReset;
      fails = 0;
      expected_q.delete();
    end else begin
      if (done_o) begin
        got = '{weight_one_o, weight_two_o, weight_three_o, inside_res_o, degenerate_o};
        if (expected_q.size() == 0) begin
          $error("result with no transaction pending");
          fails++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.w1 !== exp_r.w1) begin
            $error("weight_one expected %0d got %0d", exp_r.w1, got.w1);
            fails++;
          end
          if (got.w2 !== exp_r.w2) begin
            $error("weight_two expected %0d got %0d", exp_r.w2, got.w2);
            fails++;
          end
          if (got.w3 !== exp_r.w3) begin
            $error("weight_three expected %0d got %0d", exp_r.w3, got.w3);
            fails++;
          end
          if (got.in_tri !== exp_r.in_tri) begin
            $error("inside_res expected %0d got %0d", exp_r.in_tri, got.in_tri);
            fails++;
          end
          if (got.degen !== exp_r.degen) begin
            $error("degenerate expected %0d got %0d", exp_r.degen, got.degen);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back(locate_point(vertex1_x_i, vertex1_y_i, vertex2_x_i, vertex2_y_i,
                                          vertex3_x_i, vertex3_y_i, point_x_i, point_y_i,
                                          longint'(tol_shadow)));
      end
      if (cfg_valid_i && cfg_ready_o) tol_shadow <= cfg_tolerance_i;
    end
  end

endmodule

/* bench/triangle_barycentric_locate_tb.sv */
`timescale 1ns / 1ps

module triangle_barycentric_locate_tb;
  import tbl_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CoordW-1:0] coord_drv[8];
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [TolW-1:0] cfg_tolerance_i = '0;
  logic done_o;
  logic signed [WeightW-1:0] weight_one_o, weight_two_o, weight_three_o;
  logic inside_res_o, degenerate_o;
  int   fail_count, pending;
  logic calm;

  always #1 clk_i = ~clk_i;

  triangle_barycentric_locate dut (
    .clk_i, .rst_ni, .start, .busy,
    .vertex1_x_i(coord_drv[0]), .vertex1_y_i(coord_drv[1]),
    .vertex2_x_i(coord_drv[2]), .vertex2_y_i(coord_drv[3]),
    .vertex3_x_i(coord_drv[4]), .vertex3_y_i(coord_drv[5]),
    .point_x_i(coord_drv[6]), .point_y_i(coord_drv[7]),
    .cfg_valid_i, .cfg_ready_o, .cfg_tolerance_i,
    .done_o, .weight_one_o, .weight_two_o, .weight_three_o,
    .inside_res_o, .degenerate_o
  );

  triangle_barycentric_locate_checker checker_u (
    .clk_i, .rst_ni, .start, .busy,
    .vertex1_x_i(coord_drv[0]), .vertex1_y_i(coord_drv[1]),
    .vertex2_x_i(coord_drv[2]), .vertex2_y_i(coord_drv[3]),
    .vertex3_x_i(coord_drv[4]), .vertex3_y_i(coord_drv[5]),
    .point_x_i(coord_drv[6]), .point_y_i(coord_drv[7]),
    .cfg_valid_i, .cfg_ready_o, .cfg_tolerance_i,
    .done_o, .weight_one_o, .weight_two_o, .weight_three_o,
    .inside_res_o, .degenerate_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Issue one transaction, idling at random unless in a calm stretch.
  // Start stays high on return so the next transaction can follow directly.
  task automatic send_query(input logic [15:0] c[8]);
    while (!calm && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    for (int i = 0; i < 8; i++) coord_drv[i] <= c[i];
    do @(posedge clk_i); while (busy);
  endtask

  // Let the pipeline empty, then write the tolerance register.
  task automatic set_tolerance(input logic [15:0] tol);
    start <= 1'b0;
    wait (pending == 0);
    repeat (30) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_tolerance_i <= tol;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Random query: mostly a small triangle with the point near it.
  function automatic void make_query(output logic [15:0] c[8]);
    int base_x, base_y, span, k;
    k = $urandom_range(99);
    if (k < 20) begin
      for (int i = 0; i < 8; i++) c[i] = 16'($urandom);
    end else if (k < 30) begin
      for (int i = 0; i < 6; i++) c[i] = 16'($urandom_range(3) - 2);
      c[6] = 16'($urandom); c[7] = 16'($urandom);
    end else begin
      span = (k < 60) ? 64 : 4000;
      base_x = $urandom_range(50000) - 25000;
      base_y = $urandom_range(50000) - 25000;
      for (int i = 0; i < 8; i += 2) begin
        c[i]   = 16'(base_x + $urandom_range(span) - span / 2);
        c[i+1] = 16'(base_y + $urandom_range(span) - span / 2);
      end
      if (k < 35) begin
        c[4] = 16'(2 * c[2] - c[0]);
        c[5] = 16'(2 * c[3] - c[1]);
      end
    end
  endfunction

  logic [15:0] q[8];
  logic [15:0] tol_set[6] = '{16'd0, 16'hFFFF, 16'd66, 16'd1, 16'd4000, 16'd300};

  initial begin
    for (int i = 0; i < 8; i++) coord_drv[i] = '0;
    calm = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extremes, a right triangle with points inside, on edges, outside,
    // a degenerate triangle and huge quotients.
    q = '{16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0, 16'h0};
    send_query(q);
    q = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
    send_query(q);
    q = '{16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd100, 16'd30, 16'd30};
    send_query(q);
    q = '{16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd100, 16'd50, 16'd50};
    send_query(q);
    q = '{16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0};
    send_query(q);
    q = '{16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd100, 16'hFF9C, 16'd10};
    send_query(q);
    q = '{16'd0, 16'd0, 16'd3, 16'd3, 16'd6, 16'd6, 16'd1, 16'd1};
    send_query(q);
    q = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1, 16'h7FFF, 16'h8000};
    send_query(q);
    q = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'h8000, 16'h8000};
    send_query(q);
    q = '{16'd0, 16'd0, 16'd1000, 16'd0, 16'd0, 16'd1000, 16'd1001, 16'd0};
    send_query(q);
    q = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_query(q);
    for (int p = 0; p < 6; p++) begin
      set_tolerance(tol_set[p]);
      calm = (p == 2);
      for (int n = 0; n < 200; n++) begin
        make_query(q);
        send_query(q);
        if (n == 100) begin
          start <= 1'b0;
          wait (pending == 0);
        end
      end
      calm = 1'b0;
    end
    start <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("triangle_barycentric_locate verification clean");
    end else begin
      $display("triangle_barycentric_locate verification failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("triangle_barycentric_locate verification failed");
    $finish;
  end

endmodule
